// File: sv/hds_pkg.sv
// Shared constants for the heat diffusion stencil.
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

   localparam int GRID_MAX_DEF   = 1024;
   localparam int TEMP_WIDTH_DEF = 32;

   // coefficients are unsigned Q2.14
   localparam int COEF_WIDTH = 16;
   localparam int COEF_FRAC  = 14;
   localparam int COEF_RESET = 16384;

   localparam int SIDE_CFG_W = 11;
   localparam int SIDE_RESET = 1024;
   localparam int SIDE_MIN   = 3;

   // row and column fields of a result item
   localparam int OUT_IDX_W = 10;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SIDE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_VERT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_HORIZ = 2'd2;

   // item kind on req_tuser
   localparam logic OP_CELL  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

endpackage

`default_nettype wire

// File: sv/heat_diffusion_stencil_top.sv
// Five-point Jacobi heat stencil over a raster stream, with line buffer and pipeline.
`timescale 1ns / 1ps
`default_nettype none

// One explicit heat-equation time step on a square grid that arrives in raster order, one cell
// per item, at a sustained one item per clock while the output is not stalled: the line buffer
// is a single memory of GRID_MAX entries (upper and middle row side by side) with one read and
// one write port, and each item needs one read and at most one write. An item passes the read
// register, a difference stage, a multiplier stage and the round/saturate output register, which
// then presents the result on rsp_tvalid. Results trail the input by one row plus one cell; after
// each grid send side+1 drain items to push out the last row. Borders pass unchanged. Writing the
// side length restarts the stream at cell (0,0). The line memory needs no clearing pass after
// reset: an entry is always written before the stream reads it back into a result.
module heat_diffusion_stencil_top #(
   parameter int GRID_MAX   = hds_pkg::GRID_MAX_DEF,
   parameter int TEMP_WIDTH = hds_pkg::TEMP_WIDTH_DEF
) (
   input  wire  clock,
   input  wire  reset,

   input  wire  req_tvalid,
   output logic req_tready,
   // [TEMP_WIDTH-1:0] cell_temp
   input  wire  [((TEMP_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // opcode
   input  wire  req_tuser,

   output logic rsp_tvalid,
   input  wire  rsp_tready,
   // [TEMP_WIDTH-1:0] new_temp, then out_row (10), then out_col (10)
   output logic [((TEMP_WIDTH + 2 * hds_pkg::OUT_IDX_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   // grid_end
   output logic rsp_tlast,

   input  wire  csr_valid,
   output logic csr_ready,
   input  wire  [hds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [hds_pkg::CSR_DATA_W-1:0] csr_data
);
   import hds_pkg::*;

   localparam int TW   = TEMP_WIDTH;
   localparam int CW   = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;   // column / address
   localparam int NW   = $clog2(GRID_MAX + 1);                   // side length
   localparam int RW   = $clog2(GRID_MAX + 2);                   // row runs to side+1
   localparam int PW   = TW + 2;                                 // differences
   localparam int MW   = PW + COEF_WIDTH + 1;                    // products
   localparam int SW   = MW + 1;                                 // product sum
   localparam int DW   = SW - COEF_FRAC;                         // delta
   localparam int XW   = DW + 1;                                 // t + delta
   localparam int TDW  = ((TW + 2 * OUT_IDX_W + 7) / 8) * 8;
   localparam int GRID_RESET = (GRID_MAX < SIDE_RESET) ? GRID_MAX : SIDE_RESET;

   localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [XW-1:0] SAT_MAX = {{(XW - TW + 1){1'b0}}, {(TW - 1){1'b1}}};
   localparam logic signed [XW-1:0] SAT_MIN = {{(XW - TW + 1){1'b1}}, {(TW - 1){1'b0}}};

   // ---------------- configuration ----------------
   logic [NW-1:0]         side_len_ff;
   logic [COEF_WIDTH-1:0] coef_vert_ff;
   logic [COEF_WIDTH-1:0] coef_horiz_ff;
   logic                  csr_fire;
   logic                  grid_wr;
   logic [SIDE_CFG_W-1:0] size_raw;
   logic [NW-1:0]         size_in;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign grid_wr   = csr_fire && (csr_index == CSR_SIDE);
   assign size_raw  = csr_data[SIDE_CFG_W-1:0];

   always_comb begin
      if (32'(size_raw) < 32'(SIDE_MIN)) begin
         size_in = NW'(SIDE_MIN);
      end else if (32'(size_raw) > 32'(GRID_MAX)) begin
         size_in = NW'(GRID_MAX);
      end else begin
         size_in = NW'(size_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_len_ff   <= NW'(GRID_RESET);
         coef_vert_ff  <= COEF_WIDTH'(COEF_RESET);
         coef_horiz_ff <= COEF_WIDTH'(COEF_RESET);
      end else if (csr_fire) begin
         case (csr_index)
            CSR_SIDE:       side_len_ff   <= size_in;
            CSR_COEF_VERT:  coef_vert_ff  <= csr_data[COEF_WIDTH-1:0];
            CSR_COEF_HORIZ: coef_horiz_ff <= csr_data[COEF_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake chain ----------------
   logic req_fire;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_done, s2_adv, s3_adv, out_free, s3_free, s2_free;
   logic s1_emit_ff;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign s3_adv     = s3_valid_ff && out_free;
   assign s3_free    = !s3_valid_ff || s3_adv;
   assign s2_adv     = s2_valid_ff && s3_free;
   assign s2_free    = !s2_valid_ff || s2_adv;
   assign s1_done    = s1_valid_ff && (!s1_emit_ff || s2_free);
   assign req_tready = !s1_valid_ff || s1_done;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------- stream position ----------------
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] n_x, col_x, col_inc, er_c, ec_c;
   logic          row_lt_n, emit_c, interior_c, last_c;
   logic signed [TW-1:0] t_in_c;

   assign n_x     = RW'(side_len_ff);
   assign col_x   = RW'(col_ff);
   assign col_inc = col_x + RW'(1);
   assign row_lt_n = row_ff < n_x;
   assign emit_c  = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
   // cell finished is one row and one column behind; column zero wraps to the row above
   assign er_c    = (col_ff != '0) ? row_ff - RW'(1) : row_ff - RW'(2);
   assign ec_c    = (col_ff != '0) ? col_x - RW'(1) : n_x - RW'(1);
   assign interior_c = (er_c >= RW'(1)) && (er_c + RW'(1) < n_x)
                    && (ec_c >= RW'(1)) && (ec_c + RW'(1) < n_x);
   assign last_c  = (er_c + RW'(1) == n_x) && (ec_c + RW'(1) == n_x);
   // position decides the role: inside the grid a drain is a zero cell, beyond it data is ignored
   assign t_in_c  = (row_lt_n && (req_tuser == OP_CELL)) ? $signed(req_tdata[TW-1:0])
                                                         : '0;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (emit_c && last_c) begin
         row_in = '0;
         col_in = '0;
      end else if (col_inc >= n_x) begin
         row_in = row_ff + RW'(1);
         col_in = '0;
      end else begin
         col_in = col_inc[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || grid_wr) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_fire) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- stage 1: line memory read ----------------
   logic [2*TW-1:0]      line_mem [GRID_MAX];
   logic [2*TW-1:0]      rd_ff;
   logic signed [TW-1:0] s1_t_ff;
   logic [CW-1:0]        s1_col_ff;
   logic                 s1_wr_ff, s1_interior_ff, s1_last_ff;
   logic [CW-1:0]        s1_er_ff, s1_ec_ff;
   logic signed [TW-1:0] up_now, mid_now;
   logic                 mem_wr;

   assign up_now  = $signed(rd_ff[2*TW-1:TW]);
   assign mid_now = $signed(rd_ff[TW-1:0]);
   assign mem_wr  = s1_done && s1_wr_ff;

   // entry holds {upper row, middle row}; read and write columns always differ
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[s1_col_ff] <= {mid_now, s1_t_ff};
      end
      if (req_fire) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_done) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_t_ff        <= t_in_c;
         s1_col_ff      <= col_ff;
         s1_wr_ff       <= row_lt_n;
         s1_emit_ff     <= emit_c;
         s1_interior_ff <= interior_c;
         s1_last_ff     <= last_c;
         s1_er_ff       <= CW'(er_c);
         s1_ec_ff       <= CW'(ec_c);
      end
   end

   // window of the middle row and the held vertical neighbours
   logic signed [TW-1:0] win1_ff, win2_ff, held_up_ff, held_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff      <= '0;
         win2_ff      <= '0;
         held_up_ff   <= '0;
         held_down_ff <= '0;
      end else if (s1_done) begin
         win1_ff      <= win2_ff;
         win2_ff      <= mid_now;
         held_up_ff   <= up_now;
         held_down_ff <= s1_t_ff;
      end
   end

   // ---------------- stage 2: differences ----------------
   logic signed [PW-1:0] t_x, dv_in, dh_in;
   logic signed [PW-1:0] s2_dv_ff, s2_dh_ff;
   logic signed [TW-1:0] s2_t_ff;
   logic                 s2_interior_ff, s2_last_ff;
   logic [CW-1:0]        s2_er_ff, s2_ec_ff;

   assign t_x   = PW'(win2_ff);
   assign dv_in = PW'(held_up_ff) + PW'(held_down_ff) - (t_x <<< 1);
   assign dh_in = PW'(win1_ff) + PW'(mid_now) - (t_x <<< 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_done && s1_emit_ff) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done && s1_emit_ff) begin
         s2_t_ff        <= win2_ff;
         s2_dv_ff       <= dv_in;
         s2_dh_ff       <= dh_in;
         s2_interior_ff <= s1_interior_ff;
         s2_last_ff     <= s1_last_ff;
         s2_er_ff       <= s1_er_ff;
         s2_ec_ff       <= s1_ec_ff;
      end
   end

   // ---------------- stage 3: coefficient products ----------------
   logic signed [MW-1:0] pv_in, ph_in, s3_pv_ff, s3_ph_ff;
   logic signed [TW-1:0] s3_t_ff;
   logic                 s3_interior_ff, s3_last_ff;
   logic [CW-1:0]        s3_er_ff, s3_ec_ff;

   assign pv_in = MW'(s2_dv_ff) * MW'($signed({1'b0, coef_vert_ff}));
   assign ph_in = MW'(s2_dh_ff) * MW'($signed({1'b0, coef_horiz_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s3_valid_ff <= 1'b1;
      end else if (s3_adv) begin
         s3_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_t_ff        <= s2_t_ff;
         s3_pv_ff       <= pv_in;
         s3_ph_ff       <= ph_in;
         s3_interior_ff <= s2_interior_ff;
         s3_last_ff     <= s2_last_ff;
         s3_er_ff       <= s2_er_ff;
         s3_ec_ff       <= s2_ec_ff;
      end
   end

   // ---------------- output: round, add, saturate ----------------
   logic signed [SW-1:0] psum;
   logic signed [DW-1:0] delta;
   logic signed [XW-1:0] total;
   logic signed [TW-1:0] sat_in, temp_in;
   logic signed [TW-1:0] new_temp_ff;
   logic [CW-1:0]        out_row_ff, out_col_ff;
   logic                 rsp_valid_ff, rsp_last_ff;

   // exact Q.26 sum, round half up, drop the 14 fraction bits
   assign psum  = SW'(s3_pv_ff) + SW'(s3_ph_ff) + ROUND_HALF;
   assign delta = $signed(psum[SW-1:COEF_FRAC]);
   assign total = XW'(s3_t_ff) + XW'(delta);

   always_comb begin
      if (total > SAT_MAX) begin
         sat_in = SAT_MAX[TW-1:0];
      end else if (total < SAT_MIN) begin
         sat_in = SAT_MIN[TW-1:0];
      end else begin
         sat_in = total[TW-1:0];
      end
   end

   assign temp_in = s3_interior_ff ? sat_in : s3_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         new_temp_ff <= temp_in;
         out_row_ff  <= s3_er_ff;
         out_col_ff  <= s3_ec_ff;
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = TDW'({OUT_IDX_W'(out_col_ff), OUT_IDX_W'(out_row_ff), new_temp_ff});

   // ---------------- checks ----------------
   a_col_in_grid : assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(side_len_ff))
      else $error("column counter beyond grid size");

   a_mem_no_collide : assert property (@(posedge clock) disable iff (reset)
      (req_fire && mem_wr) |-> (col_ff != s1_col_ff))
      else $error("line memory read and write at the same column");

   a_restart_after_last : assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit_c && last_c && !grid_wr) |=> (row_ff == '0 && col_ff == '0))
      else $error("stream position not cleared after last cell of grid");

   a_emit_only_finished : assert property (@(posedge clock) disable iff (reset)
      (s1_done && s1_emit_ff) |-> s2_free)
      else $error("result issued into a busy stage");

endmodule

`default_nettype wire

// File: tb/tb_heat_diffusion_stencil_top.sv
// Self-checking testbench for the five-point heat stencil: scoreboard class and stream drivers.
`timescale 1ns / 1ps

typedef struct {
   logic [31:0] temp;
   logic [9:0]  row;
   logic [9:0]  col;
   logic        last;
} cell_result_type;

// Tracks the raster position, line buffers and window, and queues the cells due out.
class stencil_tracker_type;
   int unsigned     side;
   longint          coef_v;
   longint          coef_h;
   longint          upper_row[hds_pkg::GRID_MAX_DEF];
   longint          middle_row[hds_pkg::GRID_MAX_DEF];
   longint          window[3];
   longint          held_up;
   longint          held_down;
   int unsigned     at_row;
   int unsigned     at_col;
   cell_result_type due_cells[$];
   int unsigned     faults;
   int unsigned     items_taken;
   int unsigned     results_seen;
   int unsigned     grids_done;
   int unsigned     clamps;

   function new();
      side   = hds_pkg::SIDE_RESET;
      coef_v = hds_pkg::COEF_RESET;
      coef_h = hds_pkg::COEF_RESET;
      foreach (upper_row[i]) begin
         upper_row[i]  = 0;
         middle_row[i] = 0;
      end
      foreach (window[i]) window[i] = 0;
      held_up      = 0;
      held_down    = 0;
      at_row       = 0;
      at_col       = 0;
      faults       = 0;
      items_taken  = 0;
      results_seen = 0;
      grids_done   = 0;
      clamps       = 0;
   endfunction

   function void set_register(logic [hds_pkg::CSR_IDX_W-1:0] idx,
                              logic [hds_pkg::CSR_DATA_W-1:0] value);
      int unsigned n;
      case (idx)
         hds_pkg::CSR_SIDE: begin
            n = value[hds_pkg::SIDE_CFG_W-1:0];
            if (n < hds_pkg::SIDE_MIN) n = hds_pkg::SIDE_MIN;
            if (n > hds_pkg::GRID_MAX_DEF) n = hds_pkg::GRID_MAX_DEF;
            side   = n;
            at_row = 0;
            at_col = 0;
         end
         hds_pkg::CSR_COEF_VERT:  coef_v = value;
         hds_pkg::CSR_COEF_HORIZ: coef_h = value;
         default: ;
      endcase
   endfunction

   // Q.26 sum of both products, round half up to Q.12, then clamp to 32 bits
   function longint relax(longint t, longint up, longint down, longint left, longint right);
      longint dv;
      longint dh;
      longint sum;
      dv  = up + down - 2 * t;
      dh  = left + right - 2 * t;
      sum = t + ((coef_v * dv + coef_h * dh + 8192) >>> hds_pkg::COEF_FRAC);
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         clamps++;
      end else if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         clamps++;
      end
      return sum;
   endfunction

   function void advance_raster(logic op, logic [31:0] temp);
      int unsigned     n;
      int unsigned     row;
      int unsigned     col;
      int unsigned     er;
      int unsigned     ec;
      longint          t_in;
      longint          up_now;
      longint          mid_now;
      longint          v;
      bit              finished;
      cell_result_type r;
      n        = side;
      row      = at_row;
      col      = at_col;
      t_in     = 0;
      finished = 1'b0;
      items_taken++;
      if (col >= n) col = 0;
      // position decides the role: drains inside the grid are zero cells,
      // cells past the grid are drains
      if (row < n && op == hds_pkg::OP_CELL) t_in = $signed(temp);
      up_now  = upper_row[col];
      mid_now = middle_row[col];
      if (row < n) begin
         upper_row[col]  = mid_now;
         middle_row[col] = t_in;
      end
      window[0] = window[1];
      window[1] = window[2];
      window[2] = mid_now;
      if (row >= 2 || (row == 1 && col >= 1)) begin
         if (col >= 1) begin
            er = row - 1;
            ec = col - 1;
         end else begin
            er = row - 2;
            ec = n - 1;
         end
         v = window[1];
         if (er >= 1 && er + 1 < n && ec >= 1 && ec + 1 < n)
            v = relax(v, held_up, held_down, window[0], window[2]);
         r.temp   = v[31:0];
         r.row    = er[9:0];
         r.col    = ec[9:0];
         r.last   = (er + 1 == n) && (ec + 1 == n);
         finished = r.last;
         due_cells.push_back(r);
      end
      held_up   = up_now;
      held_down = t_in;
      if (finished) begin
         at_row = 0;
         at_col = 0;
      end else begin
         col++;
         if (col >= n) begin
            col = 0;
            row++;
         end
         at_row = row;
         at_col = col;
      end
   endfunction

   function void match_result(logic [31:0] temp, logic [9:0] row, logic [9:0] col, logic last);
      cell_result_type want;
      results_seen++;
      if (due_cells.size() == 0) begin
         faults++;
         $display("%0t: unexpected cell: expected none, got temp %h row %0d col %0d last %b",
                  $time, temp, row, col, last);
         return;
      end
      want = due_cells.pop_front();
      if (want.temp !== temp || want.row !== row || want.col !== col || want.last !== last) begin
         faults++;
         $display("%0t: cell mismatch: expected %h/%0d/%0d/%b, got %h/%0d/%0d/%b",
                  $time, want.temp, want.row, want.col, want.last, temp, row, col, last);
      end else if (last) begin
         grids_done++;
      end
   endfunction
endclass

module tb_heat_diffusion_stencil_top;
   import hds_pkg::*;

   localparam int TEMP_W       = TEMP_WIDTH_DEF;
   localparam int REQ_W        = ((TEMP_W + 7) / 8) * 8;
   localparam int RSP_W        = ((TEMP_W + 2 * OUT_IDX_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 800;
   localparam int SETTLE_WAIT  = 8;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int RANDOM_SIDE_MAX = 24;

   localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] T_MIN = 32'h8000_0000;

   typedef enum {GRID_WHOLE, GRID_CUT, GRID_OVERRUN} grid_shape_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  req_tuser  = OP_CELL;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_SIDE;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   stencil_tracker_type board;
   bit             steady_tx = 1'b0;
   bit             steady_rx = 1'b0;
   int unsigned    ready_hold = 0;
   int unsigned    roll;
   int unsigned    cycle_count = 0;
   int unsigned    random_items = 0;

   heat_diffusion_stencil_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver back-pressure: mostly short stalls, now and then a long one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady_rx) begin
         rsp_tready <= 1'b1;
      end else begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(8);
         end else if (roll < 94) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(2);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(39, 9);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.match_result(rsp_tdata[TEMP_W-1:0], rsp_tdata[TEMP_W +: OUT_IDX_W],
                            rsp_tdata[TEMP_W + OUT_IDX_W +: OUT_IDX_W], rsp_tlast);
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [31:0] pick_temp();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 3) return T_MAX;
      if (r < 6) return T_MIN;
      if (r < 8) return 32'h0;
      if (r < 10) return 32'hFFFF_FFFF;
      if (r < 40) return $urandom;
      // within +-256.0 in Q20.12
      return $urandom_range(32'h0020_0000) - 32'h0010_0000;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_coef();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return CSR_DATA_W'(COEF_RESET);
         3, 4:    return CSR_DATA_W'($urandom_range(4096));
         default: return CSR_DATA_W'($urandom_range(65535));
      endcase
   endfunction

   // side length, with junk above bit 10 that the block must drop
   function automatic logic [CSR_DATA_W-1:0] pick_side();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(19);
      if (r == 0) n = $urandom_range(2);
      else if (r < 3) n = $urandom_range(RANDOM_SIDE_MAX, 11);
      else n = $urandom_range(10, 3);
      return {5'($urandom_range(31)), 11'(n)};
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_register(idx, value);
   endtask

   task automatic send_item(input logic op, input logic [31:0] temp);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= temp;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.advance_raster(op, temp);
      gap = steady_tx ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // let every due cell come out, then cover the pipeline of items with no result
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.due_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic run_grid(input grid_shape_type shape);
      int unsigned n;
      int unsigned cells;
      int unsigned tail;
      n     = board.side;
      cells = n * n;
      tail  = n + 1;
      if (shape == GRID_CUT) begin
         cells = $urandom_range(n * n - 1, 1);
         tail  = 0;
      end else if (shape == GRID_OVERRUN) begin
         tail += $urandom_range(n, 1);
      end
      for (int unsigned k = 0; k < cells; k++) begin
         if ($urandom_range(249) == 0) settle();
         send_item(($urandom_range(24) == 0) ? OP_DRAIN : OP_CELL, pick_temp());
      end
      for (int unsigned k = 0; k < tail; k++)
         send_item(($urandom_range(6) == 0) ? OP_CELL : OP_DRAIN, $urandom);
      random_items += cells + tail;
   endtask

   initial begin
      grid_shape_type shape;
      int unsigned    r;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // 3x3, unit coefficients: centre at minimum with maximal neighbours clamps high;
      // a drain inside the grid acts as a zero cell, a cell in the flush is ignored
      write_reg(CSR_SIDE, 16'h0000);
      csr_valid <= 1'b0;
      send_item(OP_CELL, 32'h0);
      send_item(OP_CELL, T_MAX);
      send_item(OP_CELL, 32'h0);
      send_item(OP_CELL, T_MAX);
      send_item(OP_CELL, T_MIN);
      send_item(OP_CELL, T_MAX);
      send_item(OP_CELL, 32'hFFFF_FFFF);
      send_item(OP_CELL, T_MAX);
      send_item(OP_DRAIN, 32'h5A5A_5A5A);
      send_item(OP_DRAIN, 32'h0);
      send_item(OP_CELL, 32'h1234_5678);
      send_item(OP_DRAIN, 32'h0);
      send_item(OP_DRAIN, 32'h0);
      settle();

      // extreme coefficients, side written with high junk bits; clamps low.
      // One extra drain opens the next grid as a zero cell.
      write_reg(CSR_COEF_VERT, 16'hFFFF);
      write_reg(CSR_COEF_HORIZ, 16'h0000);
      write_reg(CSR_SIDE, 16'hF803);
      csr_valid <= 1'b0;
      send_item(OP_CELL, 32'h1);
      send_item(OP_CELL, T_MIN);
      send_item(OP_CELL, 32'h1);
      send_item(OP_CELL, 32'h0000_1000);
      send_item(OP_CELL, T_MAX);
      send_item(OP_CELL, 32'hFFFF_F000);
      send_item(OP_CELL, 32'h0);
      send_item(OP_CELL, T_MIN);
      send_item(OP_CELL, 32'h7FFF_FFFE);
      repeat (5) send_item(OP_DRAIN, 32'h0);
      settle();

      // oversized side clamps to the full width; one row and a few dozen cells of the next
      write_reg(CSR_COEF_VERT, pick_coef());
      write_reg(CSR_COEF_HORIZ, pick_coef());
      write_reg(CSR_SIDE, 16'h07FF);
      csr_valid <= 1'b0;
      repeat (board.side + 40) send_item(OP_CELL, pick_temp());

      while (random_items < RANDOM_ITEMS) begin
         settle();
         // the wide grid above is far too long to run whole
         if ($urandom_range(3) != 0 || board.side > RANDOM_SIDE_MAX)
            write_reg(CSR_SIDE, pick_side());
         if ($urandom_range(1) != 0) write_reg(CSR_COEF_VERT, pick_coef());
         if ($urandom_range(1) != 0) write_reg(CSR_COEF_HORIZ, pick_coef());
         csr_valid <= 1'b0;
         steady_tx = ($urandom_range(4) == 0);
         steady_rx = ($urandom_range(4) == 0);
         repeat ($urandom_range(3, 1)) begin
            r = $urandom_range(9);
            shape = (r < 8) ? GRID_WHOLE : (r == 8) ? GRID_CUT : GRID_OVERRUN;
            run_grid(shape);
         end
      end
      settle();

      $display("Run summary: %0d items taken, %0d cells compared, %0d grids finished",
               board.items_taken, board.results_seen, board.grids_done);
      $display("Sides 3 to 24 plus the 1024 clamp; %0d interior cells hit the Q20.12 limits",
               board.clamps);
      if (board.faults == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
